### rtl/core/ptp_pkg.sv
// shared types and constants of the perspective point transform
package ptp_pkg;

  localparam int COORD_W   = 32;
  localparam int MAT_W     = 64;
  localparam int NUM_REGS  = 8;
  localparam int REG_SEL_W = 3;
  localparam int CFG_IDX_W = 8;
  localparam int ROWS      = 4;
  localparam int LANES     = 3;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int H_W       = 66;
  localparam int MAG_W     = 66;
  localparam int Q_BITS    = 33;
  localparam int Q_DEPTH   = 8;
  localparam int Q_PTR_W   = 3;
  localparam int Q_CNT_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 8'd7;

  localparam logic [COORD_W-1:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG   = 32'h8000_0000;
  localparam logic [Q_BITS-1:0]  Q_LIM_POS = 33'h0_7FFF_FFFF;
  localparam logic [Q_BITS-1:0]  Q_LIM_NEG = 33'h0_8000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] proj_x;
    logic signed [COORD_W-1:0] proj_y;
    logic signed [COORD_W-1:0] proj_z;
    logic                      w_zero;
    logic                      clipped;
  } proj_t;

  typedef struct packed {
    logic                              w_zero;
    logic [LANES-1:0]                  neg;
    logic [MAG_W-1:0]                  den_mag;
    logic [LANES-1:0][MAG_W-1:0]       num_mag;
  } qent_t;

endpackage

### rtl/core/ptp_front.sv
// front end: matrix registers, multiply and row sums, classification
module ptp_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ptp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ptp_pkg::MAT_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ptp_pkg::point_t                   in_req_i,
  input  logic                              pop_i,
  output logic                              push_o,
  output ptp_pkg::qent_t                    push_data_o
);

  localparam int R = ptp_pkg::ROWS;
  localparam int L = ptp_pkg::LANES;
  localparam int HW = ptp_pkg::H_W;

  logic [ptp_pkg::MAT_W-1:0] mat_q [ptp_pkg::NUM_REGS];
  logic [ptp_pkg::MAT_W-1:0] mat_rst [ptp_pkg::NUM_REGS];
  logic [ptp_pkg::MAT_W-1:0] one_w;

  logic signed [ptp_pkg::COORD_W-1:0] coef [R][R];
  logic signed [ptp_pkg::COORD_W-1:0] pt [L];

  logic                              v1_q, v2_q, v3_q;
  logic signed [ptp_pkg::PROD_W-1:0] prod_q [R][L];
  logic signed [HW-1:0]              c3_q [R];
  logic signed [HW-1:0]              sa_q [R];
  logic signed [HW-1:0]              sb_q [R];
  logic signed [HW-1:0]              h_q [R];

  logic [ptp_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic                        accept;

  assign one_w       = ptp_pkg::MAT_W'(1) << FRAC_BITS;
  assign cfg_ready_o = 1'b1;

  // identity matrix
  always_comb begin
    for (int i = 0; i < ptp_pkg::NUM_REGS; i++) mat_rst[i] = '0;
    mat_rst[ptp_pkg::REG_ROW0_COLS01[ptp_pkg::REG_SEL_W-1:0]] = one_w;
    mat_rst[ptp_pkg::REG_ROW1_COLS01[ptp_pkg::REG_SEL_W-1:0]] = one_w << 32;
    mat_rst[ptp_pkg::REG_ROW2_COLS23[ptp_pkg::REG_SEL_W-1:0]] = one_w;
    mat_rst[ptp_pkg::REG_ROW3_COLS23[ptp_pkg::REG_SEL_W-1:0]] = one_w << 32;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ptp_pkg::NUM_REGS; i++) mat_q[i] <= mat_rst[i];
    end else if (cfg_valid_i && cfg_index_i < ptp_pkg::CFG_IDX_W'(ptp_pkg::NUM_REGS)) begin
      mat_q[cfg_index_i[ptp_pkg::REG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < R; r++) begin
      for (int c = 0; c < R; c++) begin
        coef[r][c] = $signed(mat_q[2*r + (c >> 1)][(c & 1)*32 +: 32]);
      end
    end
    pt[0] = in_req_i.point_x;
    pt[1] = in_req_i.point_y;
    pt[2] = in_req_i.point_z;
  end

  // request credits cover every item between acceptance and the back end
  assign in_stall_o = (cnt_q == ptp_pkg::Q_CNT_W'(ptp_pkg::Q_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (!accept && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v1_q  <= accept;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < R; r++) begin
      for (int c = 0; c < L; c++) begin
        prod_q[r][c] <= coef[r][c] * pt[c];
      end
      c3_q[r] <= HW'(coef[r][3]) <<< FRAC_BITS;
      sa_q[r] <= HW'(prod_q[r][0]) + HW'(prod_q[r][1]);
      sb_q[r] <= HW'(prod_q[r][2]) + c3_q[r];
      h_q[r]  <= sa_q[r] + sb_q[r];
    end
  end

  always_comb begin
    push_o              = v3_q;
    push_data_o.w_zero  = (h_q[3] == '0);
    push_data_o.den_mag = h_q[3][HW-1] ? $unsigned(-h_q[3]) : $unsigned(h_q[3]);
    for (int l = 0; l < L; l++) begin
      push_data_o.neg[l]     = h_q[l][HW-1] ^ h_q[3][HW-1];
      push_data_o.num_mag[l] = h_q[l][HW-1] ? $unsigned(-h_q[l]) : $unsigned(h_q[l]);
    end
  end

`ifndef ASSERT_OFF
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ptp_pkg::Q_CNT_W'(ptp_pkg::Q_DEPTH))
    else $error("request credit count exceeds queue depth");
`endif

endmodule

### rtl/core/ptp_queue.sv
// request queue between front and back end
module ptp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ptp_pkg::qent_t push_data_i,
  input  logic           pop_i,
  output logic           head_valid_o,
  output ptp_pkg::qent_t head_data_o
);

  ptp_pkg::qent_t                mem_q [ptp_pkg::Q_DEPTH];
  logic [ptp_pkg::Q_PTR_W-1:0]   wptr_q, rptr_q;
  logic [ptp_pkg::Q_CNT_W-1:0]   cnt_q;

  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i) rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q != ptp_pkg::Q_CNT_W'(ptp_pkg::Q_DEPTH))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
`endif

endmodule

### rtl/core/ptp_back.sv
// back end: pipelined restoring divide, saturation and output register
module ptp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  ptp_pkg::qent_t head_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ptp_pkg::proj_t out_rsp_o
);

  localparam int L   = ptp_pkg::LANES;
  localparam int MW  = ptp_pkg::MAG_W;
  localparam int QB  = ptp_pkg::Q_BITS;
  localparam int N_W = MW + FRAC_BITS;
  localparam int R_W = ((N_W > MW + QB) ? N_W : MW + QB) + 1;
  localparam int CW  = ptp_pkg::COORD_W;

  logic [QB:0]     vld_q;
  logic [R_W-1:0]  rem_q [QB+1][L];
  logic [QB-1:0]   quo_q [QB+1][L];
  logic [MW-1:0]   den_q [QB+1];
  logic [L-1:0]    neg_q [QB+1];
  logic [L-1:0]    ovf_q [QB+1];
  logic            wz_q  [QB+1];

  logic [R_W-1:0]  num0 [L];
  logic [R_W-1:0]  den_top;
  logic [R_W-1:0]  sub_d [QB];
  logic            ge    [QB][L];

  logic            out_valid_q;
  ptp_pkg::proj_t  out_q, out_d;
  logic [CW-1:0]   res [L];
  logic [L-1:0]    clip;
  logic            en;

  assign en    = !(out_valid_q && out_stall_i);
  assign pop_o = en && head_valid_i;

  always_comb begin
    den_top = R_W'(head_data_i.den_mag) << QB;
    for (int l = 0; l < L; l++) begin
      num0[l] = R_W'(head_data_i.num_mag[l]) << FRAC_BITS;
    end
    for (int s = 0; s < QB; s++) begin
      sub_d[s] = R_W'(den_q[s]) << (QB - 1 - s);
      for (int l = 0; l < L; l++) ge[s][l] = (rem_q[s][l] >= sub_d[s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[QB-1:0], head_valid_i};
      out_valid_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q[0] <= head_data_i.den_mag;
      neg_q[0] <= head_data_i.neg;
      wz_q[0]  <= head_data_i.w_zero;
      for (int l = 0; l < L; l++) begin
        rem_q[0][l] <= num0[l];
        quo_q[0][l] <= '0;
        ovf_q[0][l] <= (num0[l] >= den_top);
      end
      for (int s = 0; s < QB; s++) begin
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        wz_q[s+1]  <= wz_q[s];
        ovf_q[s+1] <= ovf_q[s];
        for (int l = 0; l < L; l++) begin
          rem_q[s+1][l] <= ge[s][l] ? rem_q[s][l] - sub_d[s] : rem_q[s][l];
          quo_q[s+1][l] <= quo_q[s][l] | (QB'(ge[s][l]) << (QB - 1 - s));
        end
      end
      out_q <= out_d;
    end
  end

  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (wz_q[QB]) begin
        clip[l] = 1'b0;
        res[l]  = '0;
      end else if (neg_q[QB][l]) begin
        clip[l] = ovf_q[QB][l] || (quo_q[QB][l] > ptp_pkg::Q_LIM_NEG);
        res[l]  = clip[l] ? ptp_pkg::SAT_NEG : CW'(0) - quo_q[QB][l][CW-1:0];
      end else begin
        clip[l] = ovf_q[QB][l] || (quo_q[QB][l] > ptp_pkg::Q_LIM_POS);
        res[l]  = clip[l] ? ptp_pkg::SAT_POS : quo_q[QB][l][CW-1:0];
      end
    end
    out_d.proj_x  = res[0];
    out_d.proj_y  = res[1];
    out_d.proj_z  = res[2];
    out_d.w_zero  = wz_q[QB];
    out_d.clipped = |clip;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef ASSERT_OFF
  a_wzero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.w_zero |-> !out_q.clipped && out_q.proj_x == '0
      && out_q.proj_y == '0 && out_q.proj_z == '0)
    else $error("zero w result carries nonzero data");
`endif

endmodule

### rtl/core/point_transform_perspective_top.sv
// top level of the 4x4 homogeneous point transform with perspective divide
// usage:
//   input channel in_valid_i / in_stall_o / in_req_i carries one point
//   (x, y, z, Q format) per request; output channel out_valid_o /
//   out_stall_i / out_rsp_o returns the projected point with w_zero and
//   clipped flags, one result per request, in order
//   the matrix is loaded through cfg_valid_i / cfg_ready_o with an index
//   of 0 to 7 (two coefficients of one row per register); other indices
//   are dropped; write only while no request is in flight
//   throughput: one request per cycle sustained
//   latency: 39 cycles from acceptance to out_valid_o, set by three
//   multiply and sum stages, the request queue, one set-up stage, one
//   stage per quotient bit of the 33-bit divider and the output register
//   reset loads the identity matrix and empties every stage
//   when the receiver stalls, the divider pipeline holds and the queue
//   absorbs the requests already in the multiply stages; the input stalls
//   once the queue credits are used up
module point_transform_perspective_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ptp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ptp_pkg::MAT_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ptp_pkg::point_t               in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ptp_pkg::proj_t                out_rsp_o
);

  logic           push, pop, head_valid;
  ptp_pkg::qent_t push_data, head_data;

  ptp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .pop_i       (pop),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ptp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  ptp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule
